/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the detector checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock, switched off while reset is high
`define EVAD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock, reset included
`define EVAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/evad_pkg.sv */
// ----------------------------------------------------------------------------
// evad_pkg
// types, widths and register codes shared by the voice activity detector
// ----------------------------------------------------------------------------
`default_nettype none

package evad_pkg;

   // field widths
   localparam int RAW_W      = 32;
   localparam int TIME_W     = 32;
   localparam int PCM_W      = 16;
   localparam int PCM_SHIFT  = 14;
   localparam int LEVEL_W    = 16;
   // square of a pcm magnitude (up to 2^30)
   localparam int SQ_W       = 2 * (PCM_W - 1) + 1;
   // square root operand and remainder widths
   localparam int OPD_W      = 2 * LEVEL_W;
   localparam int SQ_REM_W   = LEVEL_W + 2;
   localparam int SQ_T_W     = LEVEL_W + 4;

   // chunk size default
   localparam int CHUNK_MAX_DEF = 1024;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE_HOLD_MS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEECH_MS   = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLD_RST = 16'd500;
   localparam logic [TIME_W-1:0]  SILENCE_HOLD_RST    = 32'd1500;
   localparam logic [TIME_W-1:0]  MAX_SPEECH_RST      = 32'd10000;

   // input beat
   typedef struct packed {
      logic signed [RAW_W-1:0] raw_sample;
      logic                    chunk_end;
      logic [TIME_W-1:0]       now_ms;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [PCM_W-1:0] pcm_sample;
      logic                    chunk_done;
      logic [LEVEL_W-1:0]      level;
      logic                    recording_now;
      logic                    send_chunk;
      logic                    speech_started;
      logic                    speech_ended;
   } rsp_type;

   // accumulator controls
   typedef struct packed {
      logic take;
      logic add;
   } acc_ctl_type;

   // decision controls
   typedef struct packed {
      logic take;
      logic commit;
      logic done;
   } dec_ctl_type;

   // decision results
   typedef struct packed {
      logic recording_now;
      logic send_chunk;
      logic speech_started;
      logic speech_ended;
   } dec_stat_type;

endpackage

`default_nettype wire

/* design/energy_voice_activity_detector_unit.sv */
// Path: a mid-chunk beat goes from ST_ACCUM to ST_OUT and rsp_valid rises on the load; a closing
//    beat also passes ST_ROOT between them (ACC_W = 31 + log2 CHUNK_MAX).
// Flow: one beat at a time; the input reopens once ST_OUT loads the result, which rsp_stall
//    can hold back (a closing beat first takes ACC_W divide and 16 square root steps).
// Reset: synchronous, active high; clears the chunk sums, the recording state
//    and the sequencers, and loads the registers with their defaults.
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_unit
// energy based voice activity detector: pcm out, per-chunk level and decision
// ----------------------------------------------------------------------------
`default_nettype none

module energy_voice_activity_detector_unit #(
   parameter int CHUNK_MAX = evad_pkg::CHUNK_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  evad_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output evad_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [evad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [evad_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import evad_pkg::*;

   localparam int ACC_W = SQ_W + $clog2(CHUNK_MAX);
   localparam int CNT_W = $clog2(CHUNK_MAX + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ACCUM = 4'b0010,
      ST_ROOT  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic               done_ff, done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept, load;
   acc_ctl_type        acc_ctl;
   dec_ctl_type        dec_ctl;
   dec_stat_type       dec_stat;
   logic [PCM_W-1:0]   pcm;
   logic [ACC_W-1:0]   acc_sum;
   logic [CNT_W-1:0]   cnt_sum;
   logic               close;
   logic               root_done;
   logic [LEVEL_W-1:0] root;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load      = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // unit controls
   always_comb begin
      acc_ctl.take   = accept;
      acc_ctl.add    = (state_ff == ST_ACCUM);
      dec_ctl.take   = accept;
      dec_ctl.commit = load;
      dec_ctl.done   = done_ff;
   end

   evad_accum #(
      .CHUNK_MAX (CHUNK_MAX),
      .ACC_W     (ACC_W),
      .CNT_W     (CNT_W)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctl       (acc_ctl),
      .raw       (req_data.raw_sample),
      .chunk_end (req_data.chunk_end),
      .pcm       (pcm),
      .acc_sum   (acc_sum),
      .cnt_sum   (cnt_sum),
      .close     (close)
   );

   evad_root_seq #(
      .ACC_W (ACC_W),
      .CNT_W (CNT_W)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_ACCUM) && close),
      .dividend (acc_sum),
      .divisor  (cnt_sum),
      .done     (root_done),
      .root     (root)
   );

   evad_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dec_ctl),
      .now       (req_data.now_ms),
      .level     (root),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (dec_stat)
   );

   // beat sequencer
   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            done_in  = close;
            state_in = close ? ST_ROOT : ST_OUT;
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_data_in                = rsp_data_ff;
      rsp_valid_in               = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.pcm_sample     = pcm;
         rsp_data_in.chunk_done     = done_ff;
         rsp_data_in.level          = done_ff ? root : '0;
         rsp_data_in.recording_now  = dec_stat.recording_now;
         rsp_data_in.send_chunk     = dec_stat.send_chunk;
         rsp_data_in.speech_started = dec_stat.speech_started;
         rsp_data_in.speech_ended   = dec_stat.speech_ended;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/evad_accum.sv */
// ----------------------------------------------------------------------------
// evad_accum
// pcm conversion, registered square and chunk energy accumulation
// ----------------------------------------------------------------------------
`default_nettype none

module evad_accum #(
   parameter int CHUNK_MAX = 1024,
   parameter int ACC_W     = 41,
   parameter int CNT_W     = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  evad_pkg::acc_ctl_type         ctl,
   input  logic [evad_pkg::RAW_W-1:0]    raw,
   input  logic                          chunk_end,
   output logic [evad_pkg::PCM_W-1:0]    pcm,
   output logic [ACC_W-1:0]              acc_sum,
   output logic [CNT_W-1:0]              cnt_sum,
   output logic                          close
);
   import evad_pkg::*;

   logic [PCM_W-1:0]     pcm_w;
   logic [PCM_W:0]       mag;
   logic [2*PCM_W+1:0]   prod;

   logic [PCM_W-1:0]     pcm_ff, pcm_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic                 end_ff, end_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // pcm word and its magnitude
   always_comb begin
      pcm_w = raw[PCM_SHIFT +: PCM_W];
      mag   = pcm_w[PCM_W-1] ? ((~{1'b1, pcm_w}) + 1'b1) : {1'b0, pcm_w};
      prod  = mag * mag;
   end

   // sample capture
   always_comb begin
      pcm_in = pcm_ff;
      sq_in  = sq_ff;
      end_in = end_ff;
      if (ctl.take) begin
         pcm_in = pcm_w;
         sq_in  = prod[SQ_W-1:0];
         end_in = chunk_end;
      end
   end

   // running sums
   always_comb begin
      acc_sum = acc_ff + ACC_W'(sq_ff);
      cnt_sum = cnt_ff + 1'b1;
      close   = end_ff || (cnt_sum >= CNT_W'(CHUNK_MAX));
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (ctl.add) begin
         acc_in = close ? '0 : acc_sum;
         cnt_in = close ? '0 : cnt_sum;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pcm_ff <= pcm_in;
      sq_ff  <= sq_in;
      end_ff <= end_in;
   end

   // chunk state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign pcm = pcm_ff;

endmodule

`default_nettype wire

/* design/evad_root_seq.sv */
// ----------------------------------------------------------------------------
// evad_root_seq
// mean and level: restoring divide then digit square root on one subtractor
// ----------------------------------------------------------------------------
`default_nettype none

module evad_root_seq #(
   parameter int ACC_W = 41,
   parameter int CNT_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ACC_W-1:0]              dividend,
   input  logic [CNT_W-1:0]              divisor,
   output logic                          done,
   output logic [evad_pkg::LEVEL_W-1:0]  root
);
   import evad_pkg::*;

   localparam int ITER_W = $clog2(ACC_W + 1);
   localparam int SUB_W  = (CNT_W + 1 > SQ_T_W) ? CNT_W + 1 : SQ_T_W;
   localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(ACC_W - 1);
   localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(LEVEL_W - 1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_DIV  = 3'b010,
      PH_SQRT = 3'b100
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic [ACC_W-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]       div_ff, div_in;
   logic [CNT_W-1:0]       drem_ff, drem_in;
   logic [OPD_W-1:0]       rad_ff, rad_in;
   logic [SQ_REM_W-1:0]    srem_ff, srem_in;
   logic [LEVEL_W-1:0]     root_ff, root_in;

   logic [SUB_W-1:0]       sub_a, sub_b;
   logic [SUB_W:0]         sub_diff;
   logic                   sub_ge;

   // shared subtract and compare
   always_comb begin
      if (phase_ff == PH_SQRT) begin
         sub_a = SUB_W'({srem_ff, rad_ff[OPD_W-1 -: 2]});
         sub_b = SUB_W'({root_ff, 2'b01});
      end else begin
         sub_a = SUB_W'({drem_ff, quo_ff[ACC_W-1]});
         sub_b = SUB_W'(div_ff);
      end
      sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
      sub_ge   = !sub_diff[SUB_W];
   end

   // sequencer
   always_comb begin
      phase_in = phase_ff;
      iter_in  = iter_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      drem_in  = drem_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_DIV;
               iter_in  = '0;
               quo_in   = dividend;
               div_in   = divisor;
               drem_in  = '0;
            end
         end
         PH_DIV: begin
            // one quotient bit per cycle
            quo_in  = {quo_ff[ACC_W-2:0], sub_ge};
            drem_in = sub_ge ? sub_diff[CNT_W-1:0] : sub_a[CNT_W-1:0];
            iter_in = iter_ff + 1'b1;
            if (iter_ff == DIV_LAST) begin
               phase_in = PH_SQRT;
               iter_in  = '0;
               rad_in   = quo_in[OPD_W-1:0];
               srem_in  = '0;
               root_in  = '0;
            end
         end
         PH_SQRT: begin
            // one root bit per cycle, two radicand bits consumed
            root_in = {root_ff[LEVEL_W-2:0], sub_ge};
            srem_in = sub_ge ? sub_diff[SQ_REM_W-1:0] : sub_a[SQ_REM_W-1:0];
            rad_in  = {rad_ff[OPD_W-3:0], 2'b00};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == SQRT_LAST) begin
               phase_in = PH_IDLE;
               iter_in  = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            iter_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         iter_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         iter_ff  <= iter_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      drem_ff <= drem_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign done = (phase_ff == PH_SQRT) && (iter_ff == SQRT_LAST);
   assign root = root_ff;

endmodule

`default_nettype wire

/* design/evad_decide.sv */
// ----------------------------------------------------------------------------
// evad_decide
// configuration registers and the recording decision per closed chunk
// ----------------------------------------------------------------------------
`default_nettype none

module evad_decide (
   input  logic                              clock,
   input  logic                              reset,
   input  evad_pkg::dec_ctl_type             ctl,
   input  logic [evad_pkg::TIME_W-1:0]       now,
   input  logic [evad_pkg::LEVEL_W-1:0]      level,
   input  logic                              csr_we,
   input  logic [evad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [evad_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output evad_pkg::dec_stat_type            stat
);
   import evad_pkg::*;

   logic [LEVEL_W-1:0] thr_ff, thr_in;
   logic [TIME_W-1:0]  hold_ff, hold_in;
   logic [TIME_W-1:0]  max_ff, max_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               rec_ff, rec_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [TIME_W-1:0]  last_ff, last_in;

   logic               voice, rec_on, started, send, ended;
   logic [TIME_W-1:0]  start_t, last_t, speech, silence;

   // register writes
   always_comb begin
      thr_in  = thr_ff;
      hold_in = hold_ff;
      max_in  = max_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LEVEL_THRESHOLD: thr_in  = csr_wdata[LEVEL_W-1:0];
            REG_SILENCE_HOLD_MS: hold_in = csr_wdata[TIME_W-1:0];
            REG_MAX_SPEECH_MS:   max_in  = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   assign now_in = ctl.take ? now : now_ff;

   // decision for the closed chunk
   always_comb begin
      voice   = ctl.done && (level > thr_ff);
      started = voice && !rec_ff;
      rec_on  = rec_ff || voice;
      start_t = started ? now_ff : start_ff;
      last_t  = voice ? now_ff : last_ff;
      speech  = now_ff - start_t;
      silence = now_ff - last_t;
      send    = ctl.done && rec_on;
      ended   = send && ((silence > hold_ff) || (speech > max_ff));
      rec_in  = ctl.done ? (rec_on && !ended) : rec_ff;
   end

   assign start_in = start_t;
   assign last_in  = last_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= LEVEL_THRESHOLD_RST;
         hold_ff  <= SILENCE_HOLD_RST;
         max_ff   <= MAX_SPEECH_RST;
         rec_ff   <= 1'b0;
         start_ff <= '0;
         last_ff  <= '0;
      end else begin
         thr_ff  <= thr_in;
         hold_ff <= hold_in;
         max_ff  <= max_in;
         if (ctl.commit) begin
            rec_ff   <= rec_in;
            start_ff <= start_in;
            last_ff  <= last_in;
         end
      end
   end

   // time stamp of the beat at work
   always_ff @(posedge clock) begin
      now_ff <= now_in;
   end

   always_comb begin
      stat.recording_now  = rec_in;
      stat.send_chunk     = send;
      stat.speech_started = started;
      stat.speech_ended   = ended;
   end

endmodule

`default_nettype wire

/* design/evad_checker.sv */
// ----------------------------------------------------------------------------
// evad_checker
// port level checks on the detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module evad_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  evad_pkg::rsp_type                 rsp_data
);
   import evad_pkg::*;

   // a stalled result beat stays offered
   `EVAD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp beat dropped under stall")

   // one beat at a time: an accepted beat closes the input
   `EVAD_ASSERT(a_req_busy, clock, reset, req_valid && !req_stall |=> req_stall, "input open while a beat is at work")

   // mid-chunk results carry no decision
   `EVAD_ASSERT(a_mid_chunk, clock, reset, rsp_valid && !rsp_data.chunk_done |-> rsp_data.level == '0 && !rsp_data.send_chunk && !rsp_data.speech_started && !rsp_data.speech_ended, "decision fields set on a mid-chunk beat")

   // a start leaves the block recording and sending
   `EVAD_ASSERT(a_start_flags, clock, reset, rsp_valid && rsp_data.speech_started |-> rsp_data.recording_now && rsp_data.send_chunk && !rsp_data.speech_ended, "inconsistent start flags")

   // reset leaves the output empty and the input open
   `EVAD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind energy_voice_activity_detector_unit evad_checker u_evad_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
